// ===== rtl/core/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants for the motor command frame builder.
// ----------------------------------------------------------------------------
package mcf_pkg;

  // Fixed frame bytes
  localparam logic [7:0]  StartByte  = 8'hFF;
  localparam logic [7:0]  LengthByte = 8'h07;

  // CRC-16/MODBUS, reflected form
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  // Byte positions inside one frame
  localparam int unsigned IdxW       = 4;
  localparam logic [IdxW-1:0] ByteStart  = 4'd0;
  localparam logic [IdxW-1:0] ByteLength = 4'd1;
  localparam logic [IdxW-1:0] ByteRspLo  = 4'd2;
  localparam logic [IdxW-1:0] ByteRspHi  = 4'd3;
  localparam logic [IdxW-1:0] ByteLspLo  = 4'd4;
  localparam logic [IdxW-1:0] ByteLspHi  = 4'd5;
  localparam logic [IdxW-1:0] ByteFlags  = 4'd6;
  localparam logic [IdxW-1:0] ByteCrcLo  = 4'd7;
  localparam logic [IdxW-1:0] ByteCrcHi  = 4'd8;

  // Configuration register indexes
  localparam logic RegRelayMode = 1'b0;

  // Frame payload handed from the front end to the serializer
  typedef struct packed {
    logic [7:0] rsp_lo;
    logic [7:0] rsp_hi;
    logic [7:0] lsp_lo;
    logic [7:0] lsp_hi;
    logic [7:0] flags;
  } frame_desc_t;

endpackage

// ===== rtl/core/mcf_front.sv =====
// ----------------------------------------------------------------------------
// mcf_front
// Accepts a wheel command pair and turns it into frame payload bytes.
// ----------------------------------------------------------------------------
module mcf_front
  import mcf_pkg::*;
(
  input  logic [7:0]  right_command_i,
  input  logic [7:0]  left_command_i,
  input  logic [3:0]  relay_mode_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        queue_full_i,
  output logic        push_o,
  output frame_desc_t desc_o
);

  // Stall while the queue has no free slot
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  // Speed is the low six bits times 8, little-endian
  always_comb begin
    desc_o.rsp_lo = {right_command_i[4:0], 3'b000};
    desc_o.rsp_hi = {7'b0000000, right_command_i[5]};
    desc_o.lsp_lo = {left_command_i[4:0], 3'b000};
    desc_o.lsp_hi = {7'b0000000, left_command_i[5]};
    desc_o.flags  = {right_command_i[7:6], left_command_i[7:6], relay_mode_i};
  end

endmodule

// ===== rtl/core/mcf_queue.sv =====
// ----------------------------------------------------------------------------
// mcf_queue
// Short first-in first-out queue of frame payloads between front and back.
// ----------------------------------------------------------------------------
module mcf_queue
  import mcf_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t push_data_i,
  input  logic        pop_i,
  output frame_desc_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_desc_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/mcf_back.sv =====
// ----------------------------------------------------------------------------
// mcf_back
// Serializes one frame per payload, one byte a cycle while not stalled, with a running CRC.
// ----------------------------------------------------------------------------
module mcf_back
  import mcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_desc_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);

  // One byte of CRC-16/MODBUS, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            valid_q;
  logic            advance;
  logic            emit;
  logic [7:0]      cur_byte;

  assign advance = ~valid_q | ~out_stall_i;
  assign emit    = advance & ~empty_i;
  assign pop_o   = emit & (idx_q == ByteCrcHi);

  // Pick the byte for the current position
  always_comb begin
    case (idx_q)
      ByteStart:  cur_byte = StartByte;
      ByteLength: cur_byte = LengthByte;
      ByteRspLo:  cur_byte = head_i.rsp_lo;
      ByteRspHi:  cur_byte = head_i.rsp_hi;
      ByteLspLo:  cur_byte = head_i.lsp_lo;
      ByteLspHi:  cur_byte = head_i.lsp_hi;
      ByteFlags:  cur_byte = head_i.flags;
      ByteCrcLo:  cur_byte = crc_q[7:0];
      ByteCrcHi:  cur_byte = crc_q[15:8];
      default:    cur_byte = StartByte;
    endcase
  end

  // Step position on each emitted byte; restart the CRC at the start byte and fold in length to flags
  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (emit) begin
      idx_d = (idx_q == ByteCrcHi) ? ByteStart : idx_q + 1'b1;
      if (idx_q == ByteStart) begin
        crc_d = CrcInit;
      end else if (idx_q inside {[ByteLength:ByteFlags]}) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= ByteStart;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (advance) begin
        valid_q <= ~empty_i;
      end
    end
  end

  // Output register and CRC accumulator
  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (emit) begin
      byte_q <= cur_byte;
      last_q <= (idx_q == ByteCrcHi);
    end
  end

  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;
  assign out_valid_o  = valid_q;

endmodule

// ===== rtl/core/motor_command_frame_crc16_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_crc16_unit
// Builds a nine-byte motor command frame with CRC-16/MODBUS per command pair.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          handshake
//  in       input      right_command_i, left_command_i  in_valid_i / in_stall_o
//  out      output     frame_byte_o, frame_last_o       out_valid_o / out_stall_i
//  cfg      input      relay mode nibble at address 0   APB psel/penable/pwrite
//
//  Each command pair yields nine output transactions, one byte per cycle while
//  out_stall_i is low; the byte serializer sets the pair rate, though the queue
//  takes pairs ahead of it. Bytes leave through the queue and an output register.
//  The payload queue holds QueueDepth pairs; input stalls only when it is full.
//  Reset clears the queue, the serializer and sets the relay mode to 11.
// ----------------------------------------------------------------------------
module motor_command_frame_crc16_unit
  import mcf_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command input
  input  logic [7:0]  right_command_i,
  input  logic [7:0]  left_command_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  // frame output
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  relay_mode_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  frame_desc_t push_desc;
  frame_desc_t head_desc;

  // Register file: one nibble at index 0
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegRelayMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_mode_q <= 4'd11;
    end else if (cfg_wr) begin
      relay_mode_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == RegRelayMode) ? {28'd0, relay_mode_q} : 32'd0;

  mcf_front u_front (
    .right_command_i (right_command_i),
    .left_command_i  (left_command_i),
    .relay_mode_i    (relay_mode_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .queue_full_i    (q_full),
    .push_o          (push),
    .desc_o          (push_desc)
  );

  mcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .head_o      (head_desc),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  mcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_desc),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor command frame builder. Command pairs go
// in through a valid/stall channel, and the relay mode nibble is written over
// the APB port. An internal frame predictor queues the nine expected bytes per
// accepted pair. Each output transaction is compared with the oldest
// expectation. Both sides idle in random bursts, and one long receiver
// hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top
  import mcf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Register map, relay mode reset value, drain wait and receiver hold-off lengths
  localparam logic [2:0] RelayModeAddr  = 3'(4 * RegRelayMode);
  localparam logic [2:0] UnmappedAddr   = 3'd4;
  localparam logic [3:0] RelayModeReset = 4'd11;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned HoldOffCycles = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  right_command_i;
  logic [7:0]  left_command_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_beat_t frame_bytes_due[$];
  logic [3:0]  relay_mode_shadow = RelayModeReset;
  int          error_count       = 0;
  bit          src_idling        = 1'b0;
  bit          sink_idling       = 1'b0;
  int          hold_off_request  = 0;

  motor_command_frame_crc16_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .right_command_i (right_command_i),
    .left_command_i  (left_command_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frame_byte_o    (frame_byte_o),
    .frame_last_o    (frame_last_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Advance a CRC-16/MODBUS remainder by one byte, LSB first
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] data);
    logic [15:0] rem;
    rem = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      rem = rem[0] ? ((rem >> 1) ^ CrcPoly) : (rem >> 1);
    end
    return rem;
  endfunction

  // Build the nine-byte frame of one command pair and queue its bytes
  function automatic void queue_motor_frame(logic [7:0] right_cmd, logic [7:0] left_cmd,
                                            logic [3:0] relay);
    logic [7:0]  frame [9];
    logic [15:0] rspeed;
    logic [15:0] lspeed;
    logic [15:0] crc;
    rspeed = {7'b0, right_cmd[5:0], 3'b000};
    lspeed = {7'b0, left_cmd[5:0], 3'b000};
    frame[ByteStart]  = StartByte;
    frame[ByteLength] = LengthByte;
    frame[ByteRspLo]  = rspeed[7:0];
    frame[ByteRspHi]  = rspeed[15:8];
    frame[ByteLspLo]  = lspeed[7:0];
    frame[ByteLspHi]  = lspeed[15:8];
    frame[ByteFlags]  = {right_cmd[7:6], left_cmd[7:6], relay};
    crc = CrcInit;
    for (int k = ByteLength; k <= ByteFlags; k++) begin
      crc = crc16_modbus_step(crc, frame[k]);
    end
    frame[ByteCrcLo] = crc[7:0];
    frame[ByteCrcHi] = crc[15:8];
    for (int k = 0; k < 9; k++) begin
      frame_bytes_due.push_back('{data: frame[k], last: (k == ByteCrcHi)});
    end
  endfunction

  // Predict a frame for each accepted command transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      queue_motor_frame(right_command_i, left_command_i, relay_mode_shadow);
    end
  end

  // Check each accepted frame byte against the oldest expectation
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected frame byte %02h last %0b with nothing pending",
                 $time, frame_byte_o, frame_last_o);
        error_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte_o !== want.data) begin
          $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                   $time, want.data, frame_byte_o);
          error_count++;
        end
        if (frame_last_o !== want.last) begin
          $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                   $time, want.last, frame_last_o);
          error_count++;
        end
      end
    end
  end

  // Drive receiver stall: random bursts, or a long hold-off on request
  initial begin
    int  stall_left;
    bit  stall_now;
    stall_left  = 0;
    stall_now   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request > 0) begin
        stall_left       = hold_off_request;
        hold_off_request = 0;
        stall_now        = 1'b1;
      end else if (stall_left == 0) begin
        stall_left = $urandom_range(1, 19);
        stall_now  = sink_idling && ($urandom_range(0, 2) == 0);
      end
      out_stall_i <= stall_now;
      stall_left--;
    end
  end

  // Offer one command transaction and hold it until accepted
  task automatic send_command(logic [7:0] right_cmd, logic [7:0] left_cmd);
    if (src_idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    right_command_i <= right_cmd;
    left_command_i  <= left_cmd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Lower valid and wait until every expected byte has come out
  task automatic wait_frames_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == RelayModeAddr) relay_mode_shadow = data[3:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB read of the relay mode register, checked against the shadow copy
  task automatic check_relay_readback();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RelayModeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {28'b0, relay_mode_shadow}) begin
      $display("%0t: relay_mode_bits readback mismatch: expected %08h, actual %08h",
               $time, {28'b0, relay_mode_shadow}, got);
      error_count++;
    end
  endtask

  // Write the relay nibble and confirm it reads back
  task automatic set_relay_mode(logic [31:0] value);
    apb_write(RelayModeAddr, value);
    check_relay_readback();
  endtask

  task automatic test_reset_relay_mode();
    check_relay_readback();
  endtask

  // Extremes of both commands, each flag bit alone, speed limits
  task automatic test_directed_commands();
    logic [7:0] pairs [12][2];
    pairs = '{'{8'h00, 8'h00}, '{8'hFF, 8'hFF}, '{8'h3F, 8'h00}, '{8'h00, 8'h3F},
              '{8'h80, 8'h00}, '{8'h40, 8'h00}, '{8'h00, 8'h80}, '{8'h00, 8'h40},
              '{8'hC0, 8'hC0}, '{8'hAA, 8'h55}, '{8'h55, 8'hAA}, '{8'h01, 8'h20}};
    foreach (pairs[i]) send_command(pairs[i][0], pairs[i][1]);
    wait_frames_drained();
  endtask

  // Relay nibble extremes, a wide write value and an unmapped address
  task automatic test_relay_mode_settings();
    set_relay_mode(32'h0000_0000);
    send_command(8'hFF, 8'h00);
    send_command(8'h00, 8'hFF);
    wait_frames_drained();
    set_relay_mode(32'h0000_000F);
    send_command(8'h3F, 8'hC0);
    send_command(8'hC0, 8'h3F);
    wait_frames_drained();
    // keep only the low nibble of a wide value
    set_relay_mode(32'hFFFF_FFF5);
    send_command(8'h9C, 8'h63);
    wait_frames_drained();
    // drop writes outside the register map
    apb_write(UnmappedAddr, 32'h0000_000A);
    check_relay_readback();
    send_command(8'h12, 8'hED);
    wait_frames_drained();
  endtask

  // Random commands over several relay settings with idling on both sides
  task automatic test_random_commands();
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      set_relay_mode($urandom());
      for (int n = 0; n < 60; n++) begin
        send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      wait_frames_drained();
    end
  endtask

  // Hold the receiver off while commands keep coming, filling the block
  task automatic test_output_backpressure();
    src_idling       = 1'b0;
    sink_idling      = 1'b0;
    hold_off_request = HoldOffCycles;
    for (int n = 0; n < 24; n++) begin
      send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    wait_frames_drained();
  endtask

  // Back-to-back traffic, no idling on either side
  task automatic test_full_rate_commands();
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    set_relay_mode(32'h0000_000B);
    for (int n = 0; n < 60; n++) begin
      send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    wait_frames_drained();
  endtask

  // Reset, run the tests in turn, report
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    right_command_i = 8'h00;
    left_command_i  = 8'h00;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_relay_mode();
    test_directed_commands();
    test_relay_mode_settings();
    test_random_commands();
    test_output_backpressure();
    test_full_rate_commands();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
